// ===== hw/rtl/tkst_pkg.sv =====
// Package for the top-k sorted insert table: sizes, codes and request/response types.
// Used by tkst_cell and top_k_sorted_insert_table. No dependencies.
package tkst_pkg;

    localparam int ENTRIES = 10;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int SCORE_W = 32;
    localparam int HALF_W  = 16;

    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(ENTRIES);

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SUBMIT = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [SCORE_W-1:0] entry_score;
        logic [HALF_W-1:0]         entry_level;
        logic [HALF_W-1:0]         entry_name;
        logic [IDX_W-1:0]          entry_index;
    } t_in_req;

    typedef struct packed {
        logic [1:0]                status;
        logic [IDX_W-1:0]          position;
        logic signed [SCORE_W-1:0] out_score;
        logic [HALF_W-1:0]         out_level;
        logic [HALF_W-1:0]         out_name;
        logic signed [SCORE_W-1:0] lowest_score;
        logic [CNT_W-1:0]          fill_count;
    } t_out_resp;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [HALF_W-1:0]         level;
        logic [HALF_W-1:0]         name;
    } t_record;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic             load_en;
        logic             submit_en;
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] n_eff;
        t_record          rec;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             last_en;
        logic [IDX_W-1:0] last_idx;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/tkst_cell.sv =====
// One slot of the sorted table: holds a record, compares it with the incoming score,
// and shifts in its upper neighbor's record on insert. Depends on tkst_pkg.
module tkst_cell (
    input  logic                        i_clk,
    input  logic [tkst_pkg::IDX_W-1:0]  i_index,
    input  tkst_pkg::t_cell_ctl         i_ctl,
    input  tkst_pkg::t_record           i_prev_rec,
    input  logic                        i_found,
    output tkst_pkg::t_record           o_rec,
    output logic                        o_found,
    output logic                        o_placed,
    output tkst_pkg::t_record           o_rd_rec,
    output tkst_pkg::t_record           o_last_rec
);
    import tkst_pkg::*;

    t_record          r_rec;
    t_record          n_rec;
    logic [CNT_W-1:0] w_pos;
    logic             w_in_range;
    logic             w_at_n;
    logic             w_le;
    logic             w_load_hit;
    logic             w_submit_hit;

    assign w_pos      = CNT_W'(i_index);
    assign w_in_range = w_pos < i_ctl.n_eff;
    assign w_at_n     = w_pos == i_ctl.n_eff;
    assign w_le       = w_in_range && (r_rec.score <= i_ctl.rec.score);

    // First slot at or below the new score takes it; with none, the slot just past the
    // kept records does.
    assign w_submit_hit = i_ctl.submit_en && !i_found && (w_le || w_at_n);
    assign w_load_hit   = i_ctl.load_en && (i_ctl.fill < FILL_MAX) && (w_pos == i_ctl.fill);

    always_comb begin
        n_rec = r_rec;
        if (w_submit_hit || w_load_hit) begin
            n_rec = i_ctl.rec;
        end else if (i_ctl.submit_en && i_found && (w_in_range || w_at_n)) begin
            n_rec = i_prev_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec      = r_rec;
    assign o_found    = i_found || w_le;
    assign o_placed   = w_submit_hit || w_load_hit;
    assign o_rd_rec   = (i_ctl.rd_en && (i_index == i_ctl.rd_idx)) ? r_rec : '0;
    assign o_last_rec = (i_ctl.last_en && (i_index == i_ctl.last_idx)) ? r_rec : '0;

endmodule

// ===== hw/rtl/top_k_sorted_insert_table.sv =====
// Top-k sorted insert table: a row of ENTRIES cells kept in descending score order.
// The cells update at the accept edge; the result is then selected from the updated cells
// and registered into the output once the output register is free of a stalled result.
// A new request is not accepted until the previous result has been registered;
// o_in_stall is high from the accept until then.
// Reset: fill count and handshake state clear; cell contents are not reset.
// Depends on tkst_pkg and tkst_cell.
module top_k_sorted_insert_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tkst_pkg::t_in_req   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tkst_pkg::t_out_resp o_out
);
    import tkst_pkg::*;

    t_cell_ctl        w_ctl;
    t_record          w_rec   [ENTRIES];
    t_record          w_rd    [ENTRIES];
    t_record          w_last  [ENTRIES];
    logic             w_found [ENTRIES+1];
    logic             w_placed[ENTRIES];

    logic             r_busy;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [1:0]       r_op;
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] n_pos;
    logic [IDX_W-1:0] r_idx;
    t_out_resp        r_out;
    t_out_resp        n_out;

    logic             w_accept;
    logic             w_emit;
    logic [CNT_W-1:0] w_n_eff;
    logic [IDX_W-1:0] w_place_idx;
    t_record          w_rd_rec;
    t_record          w_last_rec;

    assign w_accept = i_in_valid && !r_busy;
    assign w_emit   = r_busy && (!r_out_valid || !i_out_stall);
    assign w_n_eff  = (r_fill >= FILL_MAX) ? FILL_MAX - CNT_W'(1) : r_fill;

    always_comb begin
        w_ctl.load_en   = w_accept && (i_in.opcode == OP_LOAD);
        w_ctl.submit_en = w_accept && (i_in.opcode == OP_SUBMIT);
        w_ctl.fill      = r_fill;
        w_ctl.n_eff     = w_n_eff;
        w_ctl.rec.score = i_in.entry_score;
        w_ctl.rec.level = i_in.entry_level;
        w_ctl.rec.name  = i_in.entry_name;
        w_ctl.rd_en     = (r_op == OP_READ) && (CNT_W'(r_idx) < r_fill);
        w_ctl.rd_idx    = r_idx;
        w_ctl.last_en   = r_fill != '0;
        w_ctl.last_idx  = IDX_W'(r_fill - CNT_W'(1));
    end

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        tkst_cell u_cell (
            .i_clk      (i_clk),
            .i_index    (IDX_W'(g)),
            .i_ctl      (w_ctl),
            .i_prev_rec ((g == 0) ? w_ctl.rec : w_rec[(g == 0) ? 0 : g-1]),
            .i_found    (w_found[g]),
            .o_rec      (w_rec[g]),
            .o_found    (w_found[g+1]),
            .o_placed   (w_placed[g]),
            .o_rd_rec   (w_rd[g]),
            .o_last_rec (w_last[g])
        );
    end

    // One-hot combine across the row.
    always_comb begin
        w_place_idx = '0;
        w_rd_rec    = '0;
        w_last_rec  = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            w_place_idx = w_place_idx | (IDX_W'(k) & {IDX_W{w_placed[k]}});
            w_rd_rec    = w_rd_rec | w_rd[k];
            w_last_rec  = w_last_rec | w_last[k];
        end
    end

    always_comb begin
        n_fill   = r_fill;
        n_status = ST_OK;
        n_pos    = '0;
        unique case (i_in.opcode)
            OP_LOAD: begin
                if (r_fill >= FILL_MAX) begin
                    n_status = ST_FULL;
                end else begin
                    n_pos  = w_place_idx;
                    n_fill = r_fill + CNT_W'(1);
                end
            end
            OP_SUBMIT: begin
                n_pos  = w_place_idx;
                n_fill = w_n_eff + CNT_W'(1);
            end
            OP_READ: begin
                n_pos = i_in.entry_index;
                if (CNT_W'(i_in.entry_index) >= r_fill) begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out              = '0;
        n_out.status       = r_status;
        n_out.position     = r_pos;
        n_out.out_score    = w_rd_rec.score;
        n_out.out_level    = w_rd_rec.level;
        n_out.out_name     = w_rd_rec.name;
        n_out.lowest_score = w_last_rec.score;
        n_out.fill_count   = r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
        end else begin
            if (w_accept) begin
                r_busy   <= 1'b1;
                r_fill   <= n_fill;
                r_op     <= i_in.opcode;
                r_status <= n_status;
                r_pos    <= n_pos;
                r_idx    <= i_in.entry_index;
            end else if (w_emit) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("fill count above table size");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("accepted request did not enter update stage");

    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status == ST_FULL)) |-> (o_out.fill_count == FILL_MAX))
        else $error("load refused while table not full");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_out_valid)
        else $error("result not presented after select stage");

endmodule
